// ===== hdl/lifdr_pkg.sv =====
// lifdr_pkg: shared constants, types, microcode program and arithmetic helpers
`default_nettype none
package lifdr_pkg;

   localparam int RING_DEPTH = 16;
   localparam int SLOT_W     = $clog2(RING_DEPTH);
   localparam int MOD_W      = $clog2(RING_DEPTH + 1);
   localparam int DIGIT_W    = 4;
   localparam int DIGITS     = 32 / DIGIT_W;
   localparam int DCNT_W     = $clog2(DIGITS);
   localparam int PROD_W     = 48;
   localparam int DRIVE_W    = 49;
   localparam int SUM_W      = 51;
   localparam int CSR_IDX_W  = 3;
   localparam int PC_W       = 4;

   typedef enum logic {
      ACT_ADVANCE = 1'b0,
      ACT_RECEIVE = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DECAY       = 3'd0,
      REG_DRIVE_GAIN  = 3'd1,
      REG_EXT_CURRENT = 3'd2,
      REG_THRESHOLD   = 3'd3,
      REG_REFRACTORY  = 3'd4,
      REG_DELAY       = 3'd5
   } reg_index_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_WAIT,
      OP_MODI,
      OP_MODS,
      OP_SPIKE,
      OP_REFR,
      OP_UPD,
      OP_RESP,
      OP_ACC
   } op_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_JUMP,
      C_DISPATCH,
      C_MOD_LOOP,
      C_IF_RECV,
      C_STEP_LOOP,
      C_HOLD
   } cond_type;

   typedef logic [PC_W-1:0] pc_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } ucode_type;

   typedef struct packed {
      op_type op;
      logic   accept;
      logic   out_load;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic req_recv;
      logic req_count_zero;
      logic is_recv;
      logic mod_more;
      logic steps_more;
      logic out_busy;
   } stat_type;

   typedef struct packed {
      logic        [15:0] decay;
      logic        [31:0] drive_gain;
      logic signed [31:0] ext_current;
      logic signed [31:0] threshold;
      logic        [15:0] refractory;
      logic        [3:0]  delay;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      decay:       16'd65209,
      drive_gain:  32'd6540,
      ext_current: 32'sd0,
      threshold:   32'sd1310720,
      refractory:  16'd20,
      delay:       4'd15
   };

   localparam pc_type PC_WAIT  = 4'd0;
   localparam pc_type PC_MODI  = 4'd1;
   localparam pc_type PC_MODS  = 4'd2;
   localparam pc_type PC_BR    = 4'd3;
   localparam pc_type PC_SPIKE = 4'd4;
   localparam pc_type PC_REFR  = 4'd5;
   localparam pc_type PC_UPD   = 4'd6;
   localparam pc_type PC_RESP  = 4'd7;
   localparam pc_type PC_ACC   = 4'd8;

   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      case (pc)
         PC_WAIT:  w = '{op: OP_WAIT,  cond: C_DISPATCH,  target: PC_RESP};
         PC_MODI:  w = '{op: OP_MODI,  cond: C_NEXT,      target: PC_WAIT};
         PC_MODS:  w = '{op: OP_MODS,  cond: C_MOD_LOOP,  target: PC_MODS};
         PC_BR:    w = '{op: OP_NOP,   cond: C_IF_RECV,   target: PC_ACC};
         PC_SPIKE: w = '{op: OP_SPIKE, cond: C_NEXT,      target: PC_WAIT};
         PC_REFR:  w = '{op: OP_REFR,  cond: C_NEXT,      target: PC_WAIT};
         PC_UPD:   w = '{op: OP_UPD,   cond: C_STEP_LOOP, target: PC_SPIKE};
         PC_RESP:  w = '{op: OP_RESP,  cond: C_HOLD,      target: PC_WAIT};
         PC_ACC:   w = '{op: OP_ACC,   cond: C_JUMP,      target: PC_WAIT};
         default:  w = '{op: OP_NOP,   cond: C_JUMP,      target: PC_WAIT};
      endcase
      return w;
   endfunction

   function automatic logic [MOD_W-1:0] slot_modulus(input logic [3:0] delay);
      logic [4:0] d1;
      d1 = {1'b0, delay} + 5'd1;
      if (int'(d1) > RING_DEPTH) begin
         return MOD_W'(RING_DEPTH);
      end
      return MOD_W'(d1);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
      if (x > SAT_MAX) begin
         return 32'sh7fffffff;
      end else if (x < SAT_MIN) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

endpackage
`default_nettype wire

// ===== hdl/lifdr_ifs.sv =====
// lifdr_ifs: request and response channel interfaces
`default_nettype none
interface lifdr_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic        [7:0]  step_count;
   logic        [31:0] arrival_time;
   logic signed [31:0] weight;

   modport source (output valid, output action, output step_count,
                   output arrival_time, output weight, input ready);
   modport sink   (input valid, input action, input step_count,
                   input arrival_time, input weight, output ready);
endinterface

interface lifdr_rsp_if;
   logic               valid;
   logic               ready;
   logic               spiked;
   logic signed [31:0] potential;
   logic        [31:0] spike_count;
   logic        [31:0] last_spike_time;

   modport source (output valid, output spiked, output potential,
                   output spike_count, output last_spike_time, input ready);
   modport sink   (input valid, input spiked, input potential,
                   input spike_count, input last_spike_time, output ready);
endinterface
`default_nettype wire

// ===== hdl/lif_neuron_with_delay_ring_core.sv =====
// lif_neuron_with_delay_ring_core: top level with configuration registers
//
// channel   direction  handshake      payload
// req       in         valid/ready    action, step_count, arrival_time, weight
// rsp       out        valid/ready    spiked, potential, spike_count, last_spike_time
// csr       in         csr_we         csr_index, csr_data
//
// receive request: passes through the 8-step slot index unit (one nibble a step)
// advance request: zero steps go straight to the response step; each time step
// is three microcode steps around the decay multiplier and saturating add
// reset clears state and ring valid bits together, no clearing pass
// one result register: the sequencer waits at the response step only while it is full and rsp.ready is low
`default_nettype none
module lif_neuron_with_delay_ring_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   lifdr_req_if.sink                            req,
   lifdr_rsp_if.source                          rsp,
   input  wire logic                            csr_we,
   input  wire logic [lifdr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                     csr_data
);

   lifdr_pkg::cfg_type  cfg_ff, cfg_in;
   lifdr_pkg::ctrl_type ctrl;
   lifdr_pkg::stat_type stat;

   logic [lifdr_pkg::SLOT_W-1:0] slot;
   logic [lifdr_pkg::MOD_W-1:0]  modulus;
   logic [31:0]                  dividend;
   logic                         mod_more;
   logic                         ring_we;
   logic signed [31:0]           ring_wd;
   logic signed [31:0]           ring_rd;

   assign req.ready = ctrl.op == lifdr_pkg::OP_WAIT;
   assign modulus   = lifdr_pkg::slot_modulus(cfg_ff.delay);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            lifdr_pkg::REG_DECAY:       cfg_in.decay       = csr_data[15:0];
            lifdr_pkg::REG_DRIVE_GAIN:  cfg_in.drive_gain  = csr_data;
            lifdr_pkg::REG_EXT_CURRENT: cfg_in.ext_current = csr_data;
            lifdr_pkg::REG_THRESHOLD:   cfg_in.threshold   = csr_data;
            lifdr_pkg::REG_REFRACTORY:  cfg_in.refractory  = csr_data[15:0];
            lifdr_pkg::REG_DELAY:       cfg_in.delay       = csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= lifdr_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lifdr_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   lifdr_slot u_slot (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .dividend (dividend),
      .modulus  (modulus),
      .slot     (slot),
      .more     (mod_more)
   );

   lifdr_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .slot    (slot),
      .wr_en   (ring_we),
      .wr_data (ring_wd),
      .rd_data (ring_rd)
   );

   lifdr_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .cfg      (cfg_ff),
      .req      (req),
      .rsp      (rsp),
      .mod_more (mod_more),
      .ring_rd  (ring_rd),
      .ring_we  (ring_we),
      .ring_wd  (ring_wd),
      .dividend (dividend),
      .stat     (stat)
   );

endmodule
`default_nettype wire

// ===== hdl/lifdr_seq.sv =====
// lifdr_seq: microcode sequencer with program counter and conditional jumps
`default_nettype none
module lifdr_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lifdr_pkg::stat_type stat,
   output lifdr_pkg::ctrl_type    ctrl
);

   lifdr_pkg::pc_type    pc_ff;
   lifdr_pkg::pc_type    pc_in;
   lifdr_pkg::ucode_type word;

   assign word          = lifdr_pkg::ucode_rom(pc_ff);
   assign ctrl.op       = word.op;
   assign ctrl.accept   = (word.op == lifdr_pkg::OP_WAIT) && stat.req_valid;
   assign ctrl.out_load = (word.op == lifdr_pkg::OP_RESP) && !stat.out_busy;

   always_comb begin
      pc_in = pc_ff + lifdr_pkg::PC_W'(1);
      case (word.cond)
         lifdr_pkg::C_NEXT: begin
            pc_in = pc_ff + lifdr_pkg::PC_W'(1);
         end
         lifdr_pkg::C_JUMP: begin
            pc_in = word.target;
         end
         lifdr_pkg::C_DISPATCH: begin
            if (!stat.req_valid) begin
               pc_in = pc_ff;
            end else if (!stat.req_recv && stat.req_count_zero) begin
               pc_in = word.target;
            end
         end
         lifdr_pkg::C_MOD_LOOP: begin
            if (stat.mod_more) begin
               pc_in = word.target;
            end
         end
         lifdr_pkg::C_IF_RECV: begin
            if (stat.is_recv) begin
               pc_in = word.target;
            end
         end
         lifdr_pkg::C_STEP_LOOP: begin
            if (stat.steps_more) begin
               pc_in = word.target;
            end
         end
         lifdr_pkg::C_HOLD: begin
            pc_in = stat.out_busy ? pc_ff : word.target;
         end
         default: begin
            pc_in = lifdr_pkg::PC_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= lifdr_pkg::PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/lifdr_slot.sv =====
// lifdr_slot: digit-serial slot index unit and ring slot counter
`default_nettype none
module lifdr_slot (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lifdr_pkg::ctrl_type           ctrl,
   input  wire logic [31:0]                   dividend,
   input  wire logic [lifdr_pkg::MOD_W-1:0]   modulus,
   output logic      [lifdr_pkg::SLOT_W-1:0]  slot,
   output logic                               more
);

   localparam int VW = lifdr_pkg::SLOT_W + lifdr_pkg::DIGIT_W + 1;

   logic [lifdr_pkg::SLOT_W-1:0] rem_ff, rem_in;
   logic [31:0]                  div_ff, div_in;
   logic [lifdr_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic [lifdr_pkg::MOD_W-1:0]  inc;

   function automatic logic [lifdr_pkg::SLOT_W-1:0] digit_step(
      input logic [lifdr_pkg::SLOT_W-1:0]  r,
      input logic [lifdr_pkg::DIGIT_W-1:0] d,
      input logic [lifdr_pkg::MOD_W-1:0]   m
   );
      logic [VW-1:0] v;
      logic [VW-1:0] t;
      v = VW'({r, d});
      for (int k = lifdr_pkg::DIGIT_W - 1; k >= 0; k--) begin
         t = VW'(m) << k;
         if (v >= t) begin
            v = v - t;
         end
      end
      return v[lifdr_pkg::SLOT_W-1:0];
   endfunction

   assign slot = rem_ff;
   assign more = cnt_ff != lifdr_pkg::DCNT_W'(lifdr_pkg::DIGITS - 1);
   assign inc  = lifdr_pkg::MOD_W'(rem_ff) + lifdr_pkg::MOD_W'(1);

   always_comb begin
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      case (ctrl.op)
         lifdr_pkg::OP_MODI: begin
            rem_in = '0;
            div_in = dividend;
            cnt_in = '0;
         end
         lifdr_pkg::OP_MODS: begin
            rem_in = digit_step(rem_ff, div_ff[31:32-lifdr_pkg::DIGIT_W], modulus);
            div_in = {div_ff[31-lifdr_pkg::DIGIT_W:0], {lifdr_pkg::DIGIT_W{1'b0}}};
            cnt_in = cnt_ff + lifdr_pkg::DCNT_W'(1);
         end
         lifdr_pkg::OP_UPD: begin
            // slot wraps at the modulus; step clock wrap restarts at slot zero
            rem_in = (inc == modulus || dividend == 32'hffffffff) ? '0
                   : inc[lifdr_pkg::SLOT_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

endmodule
`default_nettype wire

// ===== hdl/lifdr_ring.sv =====
// lifdr_ring: delay ring registers with per-slot valid bits
`default_nettype none
module lifdr_ring (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [lifdr_pkg::SLOT_W-1:0] slot,
   input  wire logic                         wr_en,
   input  wire logic signed [31:0]           wr_data,
   output logic signed [31:0]                rd_data
);

   logic signed [31:0]               ring_ff [lifdr_pkg::RING_DEPTH];
   logic [lifdr_pkg::RING_DEPTH-1:0] valid_ff;

   assign rd_data = valid_ff[slot] ? ring_ff[slot] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[slot] <= wr_data;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/lifdr_datapath.sv =====
// lifdr_datapath: membrane arithmetic, counters and response register
`default_nettype none
module lifdr_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lifdr_pkg::ctrl_type ctrl,
   input  wire lifdr_pkg::cfg_type  cfg,
   lifdr_req_if.sink                req,
   lifdr_rsp_if.source              rsp,
   input  wire logic                mod_more,
   input  wire logic signed [31:0]  ring_rd,
   output logic                     ring_we,
   output logic signed [31:0]       ring_wd,
   output logic [31:0]              dividend,
   output lifdr_pkg::stat_type      stat
);

   logic                                 recv_ff, recv_in;
   logic        [7:0]                    count_ff, count_in;
   logic        [31:0]                   arrival_ff, arrival_in;
   logic signed [31:0]                   weight_ff, weight_in;
   logic signed [31:0]                   membrane_ff, membrane_in;
   logic        [31:0]                   clock_ff, clock_in;
   logic        [31:0]                   stime_ff, stime_in;
   logic        [31:0]                   total_ff, total_in;
   logic                                 fired_ff, fired_in;
   logic                                 spiked_ff, spiked_in;
   logic                                 refr_ff, refr_in;
   logic signed [lifdr_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [lifdr_pkg::DRIVE_W-1:0] drive_ff, drive_in;
   logic signed [lifdr_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_spiked_ff;
   logic signed [31:0]                   rsp_potential_ff;
   logic        [31:0]                   rsp_count_ff;
   logic        [31:0]                   rsp_time_ff;

   logic signed [48:0] decay_prod;
   logic signed [64:0] drive_prod;

   assign decay_prod = $signed(membrane_ff) * $signed({1'b0, cfg.decay});
   assign drive_prod = $signed({1'b0, cfg.drive_gain}) * $signed(cfg.ext_current);

   assign dividend = recv_ff ? arrival_ff : clock_ff;

   assign stat.req_valid      = req.valid;
   assign stat.req_recv       = req.action == lifdr_pkg::ACT_RECEIVE;
   assign stat.req_count_zero = req.step_count == 8'd0;
   assign stat.is_recv        = recv_ff;
   assign stat.mod_more       = mod_more;
   assign stat.steps_more     = count_ff != 8'd1;
   assign stat.out_busy       = rsp_valid_ff && !rsp.ready;

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.spiked          = rsp_spiked_ff;
   assign rsp.potential       = rsp_potential_ff;
   assign rsp.spike_count     = rsp_count_ff;
   assign rsp.last_spike_time = rsp_time_ff;

   always_comb begin
      recv_in     = recv_ff;
      count_in    = count_ff;
      arrival_in  = arrival_ff;
      weight_in   = weight_ff;
      membrane_in = membrane_ff;
      clock_in    = clock_ff;
      stime_in    = stime_ff;
      total_in    = total_ff;
      fired_in    = fired_ff;
      spiked_in   = spiked_ff;
      refr_in     = refr_ff;
      prod_in     = prod_ff;
      drive_in    = drive_ff;
      sum_in      = sum_ff;
      ring_we     = 1'b0;
      ring_wd     = '0;
      if (ctrl.accept) begin
         recv_in    = req.action == lifdr_pkg::ACT_RECEIVE;
         count_in   = req.step_count;
         arrival_in = req.arrival_time;
         weight_in  = req.weight;
         spiked_in  = 1'b0;
      end
      case (ctrl.op)
         lifdr_pkg::OP_MODI: begin
            drive_in = drive_prod[64:16];
         end
         lifdr_pkg::OP_SPIKE: begin
            if (membrane_ff > $signed(cfg.threshold)) begin
               total_in  = total_ff + 32'd1;
               stime_in  = clock_ff;
               fired_in  = 1'b1;
               spiked_in = 1'b1;
            end
            prod_in = decay_prod[lifdr_pkg::PROD_W-1:0];
         end
         lifdr_pkg::OP_REFR: begin
            refr_in = fired_ff && ((clock_ff - stime_ff) <= {16'd0, cfg.refractory});
            sum_in  = lifdr_pkg::SUM_W'($signed(prod_ff[lifdr_pkg::PROD_W-1:16]))
                    + lifdr_pkg::SUM_W'(drive_ff);
         end
         lifdr_pkg::OP_UPD: begin
            membrane_in = refr_ff ? 32'sd0
                        : lifdr_pkg::sat32(sum_ff + lifdr_pkg::SUM_W'(ring_rd));
            ring_we     = 1'b1;
            ring_wd     = '0;
            clock_in    = clock_ff + 32'd1;
            count_in    = count_ff - 8'd1;
         end
         lifdr_pkg::OP_ACC: begin
            ring_we = 1'b1;
            ring_wd = lifdr_pkg::sat32(lifdr_pkg::SUM_W'(ring_rd)
                                     + lifdr_pkg::SUM_W'(weight_ff));
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         membrane_ff  <= '0;
         clock_ff     <= '0;
         stime_ff     <= '0;
         total_ff     <= '0;
         fired_ff     <= 1'b0;
         spiked_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         membrane_ff  <= membrane_in;
         clock_ff     <= clock_in;
         stime_ff     <= stime_in;
         total_ff     <= total_in;
         fired_ff     <= fired_in;
         spiked_ff    <= spiked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      recv_ff    <= recv_in;
      count_ff   <= count_in;
      arrival_ff <= arrival_in;
      weight_ff  <= weight_in;
      refr_ff    <= refr_in;
      prod_ff    <= prod_in;
      drive_ff   <= drive_in;
      sum_ff     <= sum_in;
      if (ctrl.out_load) begin
         rsp_spiked_ff    <= spiked_ff;
         rsp_potential_ff <= membrane_ff;
         rsp_count_ff     <= total_ff;
         rsp_time_ff      <= stime_ff;
      end
   end

endmodule
`default_nettype wire
